>>> hdl/ffha_pkg.sv
package ffha_pkg;

	// Default build parameters of the allocator.
	localparam int unsigned ARENA_BYTES_DEF  = 65536;
	localparam int unsigned ALIGN_BYTES_DEF  = 8;
	localparam int unsigned HEADER_BYTES_DEF = 24;

	// Fixed field widths of the request, response and configuration ports.
	localparam int unsigned REQ_W      = 17;
	localparam int unsigned ADDR_W     = 32;
	localparam int unsigned LIMIT_W    = 17;
	localparam int unsigned SZ_W       = REQ_W + 1;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 32;

	// Reset value of the growth limit register.
	localparam logic [LIMIT_W-1:0] HEAP_LIMIT_RST = 17'h10000;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HEAP_LIMIT = 1'b1;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OOM      = 2'd1,
		ST_NOT_USED = 2'd2,
		ST_OUTSIDE  = 2'd3
	} status_t;

endpackage

>>> hdl/ffha_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
module ffha_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/first_fit_heap_allocator.sv
// First-fit heap allocator over an arena of in-band block headers. Each request (op 0 allocate,
// op 1 free) gives exactly one response. Block headers live in two on-chip RAMs indexed by
// granule (used mark and size in one, previous-block offset in the other), each with a
// registered read. An allocate walks the block list from offset 0, then marks, splits or
// grows the break; after growing it runs a merge check on the former tail block. A free
// walks to the target and then merges the freed block with its free neighbors on both sides.
// One request is in work at a time; the response register lets the next request enter while
// the last response waits. ALIGN_BYTES must be a power of two and ARENA_BYTES a multiple of it.
// No clearing pass is needed after reset: only headers of existing blocks are ever read.
module first_fit_heap_allocator #(
	parameter int unsigned ARENA_BYTES  = ffha_pkg::ARENA_BYTES_DEF,
	parameter int unsigned ALIGN_BYTES  = ffha_pkg::ALIGN_BYTES_DEF,
	parameter int unsigned HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [ffha_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ffha_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            op,
	input  logic [ffha_pkg::REQ_W-1:0]      req_size,
	input  logic [ffha_pkg::ADDR_W-1:0]     req_address,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [ffha_pkg::ADDR_W-1:0]     result_address,
	output logic [1:0]                      status
);

	localparam int unsigned ALIGN_SH = $clog2(ALIGN_BYTES);
	localparam int unsigned HDR      = (HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
	localparam int unsigned GRANULES = ARENA_BYTES / ALIGN_BYTES;
	localparam int unsigned GW       = $clog2(GRANULES);
	localparam int unsigned OW       = $clog2(ARENA_BYTES) + 1;
	localparam int unsigned AW       = ((OW > ffha_pkg::SZ_W) ? OW : ffha_pkg::SZ_W) + 1;
	localparam int unsigned MW       = 1 + OW;
	localparam int unsigned AD       = ffha_pkg::ADDR_W;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_WALK  = 9'b000000010,
		S_HCHK  = 9'b000000100,
		S_SPLIT = 9'b000001000,
		S_GROW  = 9'b000010000,
		S_MRD   = 9'b000100000,
		S_MCHK0 = 9'b001000000,
		S_MCHK1 = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	state_t                       state_q, state_d;
	logic [OW-1:0]                off_q, off_d;
	logic [AW-1:0]                sz_q, sz_d;
	logic                         op_q, op_d;
	logic [AD-1:0]                target_q, target_d;
	logic [OW-1:0]                hsize_q, hsize_d;
	logic [OW-1:0]                prev_q, prev_d;
	logic [OW-1:0]                moff_q, moff_d;
	logic [OW-1:0]                other_q, other_d;
	logic [OW-1:0]                bsize_q, bsize_d;
	logic                         second_q, second_d;
	logic                         started_q, started_d;
	logic [OW-1:0]                last_q, last_d;
	logic [OW-1:0]                brk_q, brk_d;
	logic [AD-1:0]                base_q;
	logic [ffha_pkg::LIMIT_W-1:0] limit_q;
	logic [AD-1:0]                res_addr_q, res_addr_d;
	ffha_pkg::status_t            res_stat_q, res_stat_d;
	logic                         out_valid_q;
	logic [AD-1:0]                out_addr_q;
	ffha_pkg::status_t            out_stat_q;
	logic                         load_out;

	// Header RAM ports.
	logic          m_we, m_re;
	logic [GW-1:0] m_waddr, m_raddr;
	logic [MW-1:0] m_wdata, m_rdata;
	logic          p_we;
	logic [GW-1:0] p_waddr;
	logic [OW-1:0] p_wdata, p_rdata;

	// Granule index of a byte offset.
	function automatic logic [GW-1:0] gidx(input logic [OW-1:0] o);
		logic [OW-1:0] s;
		s = o >> ALIGN_SH;
		return s[GW-1:0];
	endfunction

	// An offset names an existing block when it does not pass the tail.
	function automatic logic is_blk(input logic [OW-1:0] o, input logic st,
			input logic [OW-1:0] lst);
		return st && (o <= lst);
	endfunction

	ffha_ram #(.WIDTH(MW), .DEPTH(GRANULES)) u_main_ram (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_waddr),
		.wdata (m_wdata),
		.re    (m_re),
		.raddr (m_raddr),
		.rdata (m_rdata)
	);

	ffha_ram #(.WIDTH(OW), .DEPTH(GRANULES)) u_prev_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.re    (m_re),
		.raddr (m_raddr),
		.rdata (p_rdata)
	);

	// Sequencer: walk, check, split, grow and merge.
	always_comb begin
		logic [AW-1:0] sz_raw;
		logic [AW-1:0] sz_rnd;
		logic [AD-1:0] rel;
		logic          h_used;
		logic [OW-1:0] h_size;
		logic [OW-1:0] nxt;
		logic [OW-1:0] nb;
		logic [OW-1:0] after;
		logic [OW-1:0] other;
		logic [AW-1:0] lim;
		logic [AW-1:0] need;

		state_d    = state_q;
		off_d      = off_q;
		sz_d       = sz_q;
		op_d       = op_q;
		target_d   = target_q;
		hsize_d    = hsize_q;
		prev_d     = prev_q;
		moff_d     = moff_q;
		other_d    = other_q;
		bsize_d    = bsize_q;
		second_d   = second_q;
		started_d  = started_q;
		last_d     = last_q;
		brk_d      = brk_q;
		res_addr_d = res_addr_q;
		res_stat_d = res_stat_q;
		load_out   = 1'b0;
		m_we       = 1'b0;
		m_waddr    = gidx(off_q);
		m_wdata    = '0;
		m_re       = 1'b0;
		m_raddr    = gidx(off_q);
		p_we       = 1'b0;
		p_waddr    = gidx(off_q);
		p_wdata    = off_q;

		sz_raw = AW'(req_size) + AW'(req_size == '0);
		sz_rnd = (sz_raw + AW'(ALIGN_BYTES - 1)) & ~AW'(ALIGN_BYTES - 1);
		rel    = req_address - base_q;
		h_used = m_rdata[MW-1];
		h_size = m_rdata[OW-1:0];
		nxt    = off_q + OW'(HDR) + h_size;
		nb     = off_q + OW'(HDR) + sz_q[OW-1:0];
		after  = off_q + OW'(HDR) + hsize_q;
		other  = moff_q + OW'(HDR) + h_size;
		lim    = (AW'(limit_q) > AW'(ARENA_BYTES)) ? AW'(ARENA_BYTES) : AW'(limit_q);
		need   = AW'(HDR) + sz_q;

		case (state_q)
			// Take a request and set up the walk; a null or too-low free finishes at once.
			S_IDLE: begin
				if (in_valid) begin
					op_d       = op;
					off_d      = '0;
					sz_d       = sz_rnd;
					res_addr_d = '0;
					res_stat_d = ffha_pkg::ST_OK;
					if (op == ffha_pkg::OP_ALLOC) begin
						state_d = S_WALK;
					end else if (req_address == '0) begin
						state_d = S_DONE;
					end else if (rel < AD'(HDR)) begin
						res_stat_d = ffha_pkg::ST_OUTSIDE;
						state_d    = S_DONE;
					end else begin
						target_d = rel - AD'(HDR);
						state_d  = S_WALK;
					end
				end
			end
			// Read the current block header or leave the walk.
			S_WALK: begin
				if (op_q == ffha_pkg::OP_ALLOC) begin
					if (!is_blk(off_q, started_q, last_q)) begin
						state_d = S_GROW;
					end else begin
						m_re    = 1'b1;
						state_d = S_HCHK;
					end
				end else if (!is_blk(off_q, started_q, last_q) || (AD'(off_q) > target_q)) begin
					res_stat_d = ffha_pkg::ST_OUTSIDE;
					state_d    = S_DONE;
				end else begin
					m_re    = 1'b1;
					state_d = S_HCHK;
				end
			end
			// Inspect the header just read.
			S_HCHK: begin
				if (op_q == ffha_pkg::OP_ALLOC) begin
					if (!h_used && (AW'(h_size) >= sz_q)) begin
						m_we       = 1'b1;
						res_addr_d = base_q + AD'(off_q) + AD'(HDR);
						if ((AW'(h_size) - sz_q) > AW'(HDR + 1)) begin
							m_wdata = {1'b1, sz_q[OW-1:0]};
							p_we    = 1'b1;
							p_waddr = gidx(nb);
							p_wdata = off_q;
							hsize_d = h_size;
							if (last_q == off_q) begin
								last_d = nb;
							end
							state_d = S_SPLIT;
						end else begin
							m_wdata = {1'b1, h_size};
							state_d = S_DONE;
						end
					end else begin
						off_d   = nxt;
						state_d = S_WALK;
					end
				end else if (AD'(off_q) == target_q) begin
					if (!h_used) begin
						res_stat_d = ffha_pkg::ST_NOT_USED;
						state_d    = S_DONE;
					end else begin
						m_we     = 1'b1;
						m_wdata  = {1'b0, h_size};
						prev_d   = p_rdata;
						moff_d   = off_q;
						second_d = (target_q != '0);
						state_d  = S_MRD;
					end
				end else begin
					off_d   = nxt;
					state_d = S_WALK;
				end
			end
			// Write the split-off remainder and relink the block after it.
			S_SPLIT: begin
				m_we    = 1'b1;
				m_waddr = gidx(nb);
				m_wdata = {1'b0, hsize_q - sz_q[OW-1:0] - OW'(HDR)};
				if (is_blk(after, started_q, last_q)) begin
					p_we    = 1'b1;
					p_waddr = gidx(after);
					p_wdata = nb;
				end
				state_d = S_DONE;
			end
			// Append a new block at the break, or report out of memory.
			S_GROW: begin
				if ((AW'(brk_q) > lim) || ((lim - AW'(brk_q)) < need)) begin
					res_stat_d = ffha_pkg::ST_OOM;
					res_addr_d = '0;
					state_d    = S_DONE;
				end else begin
					m_we       = 1'b1;
					m_waddr    = gidx(brk_q);
					m_wdata    = {1'b1, sz_q[OW-1:0]};
					p_we       = 1'b1;
					p_waddr    = gidx(brk_q);
					p_wdata    = started_q ? last_q : '0;
					brk_d      = brk_q + OW'(HDR) + sz_q[OW-1:0];
					last_d     = brk_q;
					started_d  = 1'b1;
					res_addr_d = base_q + AD'(brk_q) + AD'(HDR);
					if (started_q) begin
						moff_d   = last_q;
						second_d = 1'b0;
						state_d  = S_MRD;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			// Merge: read the block that may absorb its successor.
			S_MRD: begin
				m_re    = 1'b1;
				m_raddr = gidx(moff_q);
				state_d = S_MCHK0;
			end
			// Merge: check the block, then read its successor.
			S_MCHK0: begin
				if (h_used || !is_blk(other, started_q, last_q)) begin
					if (second_q) begin
						moff_d   = prev_q;
						second_d = 1'b0;
						state_d  = S_MRD;
					end else begin
						state_d = S_DONE;
					end
				end else begin
					m_re    = 1'b1;
					m_raddr = gidx(other);
					bsize_d = h_size;
					other_d = other;
					state_d = S_MCHK1;
				end
			end
			// Merge: absorb a free successor and relink the block after it.
			S_MCHK1: begin
				if (!h_used) begin
					m_we    = 1'b1;
					m_waddr = gidx(moff_q);
					m_wdata = {1'b0, bsize_q + OW'(HDR) + h_size};
					if (other_q == last_q) begin
						last_d = moff_q;
					end
					if (is_blk(other_q + OW'(HDR) + h_size, started_q, last_q)) begin
						p_we    = 1'b1;
						p_waddr = gidx(other_q + OW'(HDR) + h_size);
						p_wdata = moff_q;
					end
				end
				if (second_q) begin
					moff_d   = prev_q;
					second_d = 1'b0;
					state_d  = S_MRD;
				end else begin
					state_d = S_DONE;
				end
			end
			// Hand the response to the output register once it is free.
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control and state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			second_q    <= 1'b0;
			started_q   <= 1'b0;
			last_q      <= '0;
			brk_q       <= '0;
			base_q      <= '0;
			limit_q     <= ffha_pkg::HEAP_LIMIT_RST;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			second_q  <= second_d;
			started_q <= started_d;
			last_q    <= last_d;
			brk_q     <= brk_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_write) begin
				case (cfg_index)
					ffha_pkg::REG_HEAP_BASE: begin
						base_q <= cfg_data;
					end
					ffha_pkg::REG_HEAP_LIMIT: begin
						limit_q <= cfg_data[ffha_pkg::LIMIT_W-1:0];
					end
					default: begin
						base_q <= base_q;
					end
				endcase
			end
		end
	end

	// Working registers of the request in progress.
	always_ff @(posedge clk) begin
		off_q      <= off_d;
		sz_q       <= sz_d;
		op_q       <= op_d;
		target_q   <= target_d;
		hsize_q    <= hsize_d;
		prev_q     <= prev_d;
		moff_q     <= moff_d;
		other_q    <= other_d;
		bsize_q    <= bsize_d;
		res_addr_q <= res_addr_d;
		res_stat_q <= res_stat_d;
		if (load_out) begin
			out_addr_q <= res_addr_q;
			out_stat_q <= res_stat_q;
		end
	end

	assign in_ready       = (state_q == S_IDLE);
	assign out_valid      = out_valid_q;
	assign result_address = out_addr_q;
	assign status         = out_stat_q;

	// The break never passes the arena.
	assert property (@(posedge clk) disable iff (!arst_n) brk_q <= OW'(ARENA_BYTES))
		else $error("break offset beyond arena");

	// The tail block always starts below the break.
	assert property (@(posedge clk) disable iff (!arst_n) started_q |-> (last_q < brk_q))
		else $error("tail block at or beyond break");

	// An out-of-memory response carries a null address.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_stat_q == ffha_pkg::ST_OOM)) |-> (out_addr_q == '0))
		else $error("out-of-memory response with nonzero address");

	// A new response appears only from the completion state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("response raised outside completion");

endmodule

>>> bench/first_fit_heap_allocator_test.sv
module first_fit_heap_allocator_test;

	localparam int unsigned ARENA = ffha_pkg::ARENA_BYTES_DEF;
	localparam int unsigned ALIGN = ffha_pkg::ALIGN_BYTES_DEF;
	localparam int unsigned HDR =
		(ffha_pkg::HEADER_BYTES_DEF + ffha_pkg::ALIGN_BYTES_DEF - 1)
		/ ffha_pkg::ALIGN_BYTES_DEF * ffha_pkg::ALIGN_BYTES_DEF;
	localparam int unsigned GRANULES = ARENA / ALIGN;
	localparam int unsigned STALL_LIMIT = 40000;

	typedef struct {
		ffha_pkg::op_t op;
		logic [16:0]   size;
		logic [31:0]   address;
	} heap_req_t;

	typedef struct {
		logic [31:0]       address;
		ffha_pkg::status_t status;
	} heap_resp_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_write;
	logic [0:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic        op;
	logic [16:0] req_size;
	logic [31:0] req_address;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] result_address;
	logic [1:0]  status;

	first_fit_heap_allocator u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .req_size(req_size), .req_address(req_address),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_address(result_address), .status(status)
	);

	// Shadow copy of the arena headers and the allocator registers.
	bit          blk_used [GRANULES];
	int unsigned blk_size [GRANULES];
	int unsigned blk_prev [GRANULES];
	bit          started;
	int unsigned tail_off;
	int unsigned brk_off;
	logic [31:0] base_reg;
	logic [16:0] limit_reg;

	heap_req_t   pending_reqs[$];
	heap_resp_t  expected_resps[$];
	int unsigned live_offs[$];
	int unsigned freed_offs[$];

	int  fail_count;
	int  n_alloc_ok, n_oom, n_free_ok, n_free_err;
	bit  in_fire;
	int  in_gap, out_gap;
	bit  steady;
	int  stall_cycles;

	function automatic int unsigned gidx(int unsigned o);
		return (o / ALIGN) % GRANULES;
	endfunction

	function automatic int unsigned next_off(int unsigned o);
		return o + HDR + blk_size[gidx(o)];
	endfunction

	function automatic bit exists(int unsigned o);
		return started && o <= tail_off;
	endfunction

	// Absorb a free successor into the block at o.
	function automatic void absorb_next(int unsigned o);
		int unsigned other, after;
		other = next_off(o);
		if (blk_used[gidx(o)] || !exists(other) || blk_used[gidx(other)])
			return;
		after = next_off(other);
		blk_size[gidx(o)] += HDR + blk_size[gidx(other)];
		if (other == tail_off)
			tail_off = o;
		if (exists(after))
			blk_prev[gidx(after)] = o;
	endfunction

	// Cut the unused rest of a block off as a free block of its own.
	function automatic void carve(int unsigned o, int unsigned sz);
		int unsigned nb, after;
		if (blk_size[gidx(o)] - sz <= HDR + 1)
			return;
		nb = o + HDR + sz;
		blk_used[gidx(nb)] = 0;
		blk_size[gidx(nb)] = blk_size[gidx(o)] - sz - HDR;
		blk_prev[gidx(nb)] = o;
		if (tail_off == o)
			tail_off = nb;
		blk_size[gidx(o)] = sz;
		after = next_off(nb);
		if (exists(after))
			blk_prev[gidx(after)] = nb;
	endfunction

	function automatic heap_resp_t predict_alloc(logic [16:0] req);
		heap_resp_t  r;
		int unsigned sz, o, lim, nb, p;
		bit          had;
		sz = req + (req == 0);
		sz = (sz + ALIGN - 1) / ALIGN * ALIGN;
		o = 0;
		while (exists(o)) begin
			if (!blk_used[gidx(o)] && blk_size[gidx(o)] >= sz) begin
				blk_used[gidx(o)] = 1;
				carve(o, sz);
				r.address = base_reg + o + HDR;
				r.status = ffha_pkg::ST_OK;
				return r;
			end
			o = next_off(o);
		end
		lim = (limit_reg < ARENA) ? limit_reg : ARENA;
		if (brk_off > lim || lim - brk_off < HDR + sz) begin
			r.address = '0;
			r.status = ffha_pkg::ST_OOM;
			return r;
		end
		nb = brk_off;
		brk_off += HDR + sz;
		blk_used[gidx(nb)] = 1;
		blk_size[gidx(nb)] = sz;
		blk_prev[gidx(nb)] = started ? tail_off : 0;
		had = started;
		p = blk_prev[gidx(nb)];
		tail_off = nb;
		started = 1;
		if (had)
			absorb_next(p);
		r.address = base_reg + nb + HDR;
		r.status = ffha_pkg::ST_OK;
		return r;
	endfunction

	function automatic ffha_pkg::status_t predict_free(logic [31:0] addr);
		logic [31:0] rel;
		int unsigned target, o;
		if (addr == 0)
			return ffha_pkg::ST_OK;
		rel = addr - base_reg;
		if (rel < HDR)
			return ffha_pkg::ST_OUTSIDE;
		target = rel - HDR;
		o = 0;
		while (exists(o) && o < target)
			o = next_off(o);
		if (!exists(o) || o != target)
			return ffha_pkg::ST_OUTSIDE;
		if (!blk_used[gidx(target)])
			return ffha_pkg::ST_NOT_USED;
		blk_used[gidx(target)] = 0;
		absorb_next(target);
		if (target != 0)
			absorb_next(blk_prev[gidx(target)]);
		return ffha_pkg::ST_OK;
	endfunction

	// Queue one request together with the response it must produce.
	task automatic push_req(ffha_pkg::op_t o, logic [16:0] sz, logic [31:0] addr,
			output logic [31:0] got);
		heap_req_t  q;
		heap_resp_t r;
		int         k;
		q.op = o;
		q.size = sz;
		q.address = addr;
		if (o == ffha_pkg::OP_ALLOC) begin
			r = predict_alloc(sz);
			if (r.status == ffha_pkg::ST_OK) begin
				n_alloc_ok++;
				if (r.address != 0)
					live_offs.push_back(r.address - base_reg);
			end else
				n_oom++;
		end else begin
			r.address = '0;
			r.status = predict_free(addr);
			if (r.status == ffha_pkg::ST_OK && addr != 0) begin
				n_free_ok++;
				for (k = 0; k < live_offs.size(); k++)
					if (live_offs[k] == addr - base_reg) begin
						live_offs.delete(k);
						break;
					end
				freed_offs.push_back(addr - base_reg);
				if (freed_offs.size() > 64)
					void'(freed_offs.pop_front());
			end else if (r.status != ffha_pkg::ST_OK)
				n_free_err++;
		end
		got = r.address;
		pending_reqs.push_back(q);
		expected_resps.push_back(r);
	endtask

	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Wait until the block has answered everything.
	task automatic drain();
		while (pending_reqs.size() != 0 || expected_resps.size() != 0 || in_valid)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_write = 1'b0;
		if (idx == ffha_pkg::REG_HEAP_BASE)
			base_reg = val;
		else
			limit_reg = val[16:0];
	endtask

	// Random traffic: mostly allocations and frees of live blocks, some noise.
	task automatic random_phase(int count);
		int          n, r, k;
		logic [16:0] sz;
		logic [31:0] a, got;
		for (n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 52) begin
				k = $urandom_range(0, 99);
				if (k < 70)
					sz = 17'($urandom_range(0, 200));
				else if (k < 90)
					sz = 17'($urandom_range(0, 2000));
				else if (k < 97)
					sz = 17'($urandom_range(0, 16000));
				else
					sz = $urandom_range(0, 1) ? 17'd65536 : 17'($urandom_range(0, 65536));
				push_req(ffha_pkg::OP_ALLOC, sz, $urandom(), got);
			end else begin
				k = $urandom_range(0, 99);
				if (k < 65 && live_offs.size() != 0)
					a = base_reg + live_offs[$urandom_range(0, live_offs.size() - 1)];
				else if (k < 73)
					a = '0;
				else if (k < 83 && freed_offs.size() != 0)
					a = base_reg + freed_offs[$urandom_range(0, freed_offs.size() - 1)];
				else if (k < 90 && live_offs.size() != 0)
					a = base_reg + live_offs[$urandom_range(0, live_offs.size() - 1)]
						+ ALIGN * $urandom_range(1, 3);
				else
					a = $urandom();
				push_req(ffha_pkg::OP_FREE, 17'($urandom()), a, got);
			end
		end
	endtask

	// Clock.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Request driver: presents queued requests with random gaps.
	always @(negedge clk) begin
		if (!in_valid || in_fire) begin
			if (in_gap > 0) begin
				in_gap <= in_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_reqs.size() != 0 && arst_n) begin
				heap_req_t q;
				q = pending_reqs.pop_front();
				op <= q.op;
				req_size <= q.size;
				req_address <= q.address;
				in_valid <= 1'b1;
				in_gap <= pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Response side back-pressure.
	always @(negedge clk) begin
		if (out_gap > 0) begin
			out_gap <= out_gap - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (!steady && $urandom_range(0, 9) < 3)
				out_gap <= pick_gap();
		end
	end

	// Monitor: compare each response with the oldest prediction.
	always @(posedge clk) begin
		in_fire <= in_valid && in_ready;
		if (in_valid && in_ready || out_valid && out_ready)
			stall_cycles <= 0;
		else if (pending_reqs.size() != 0 || expected_resps.size() != 0)
			stall_cycles <= stall_cycles + 1;
		if (out_valid && out_ready) begin
			if (expected_resps.size() == 0) begin
				$error("response with nothing outstanding: result_address %h status %0d",
					result_address, status);
				fail_count++;
			end else begin
				heap_resp_t e;
				e = expected_resps.pop_front();
				if (result_address !== e.address) begin
					$error("result_address: expected %h actual %h", e.address, result_address);
					fail_count++;
				end
				if (status !== e.status) begin
					$error("status: expected %0d actual %0d", e.status, status);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on a hung handshake.
	always @(posedge clk) begin
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout with %0d responses outstanding", expected_resps.size());
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		logic [31:0] a0, a1, a2, a3, a4, got;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		op = 1'b0;
		req_size = '0;
		req_address = '0;
		out_ready = 1'b0;
		in_gap = 0;
		out_gap = 0;
		in_fire = 1'b0;
		steady = 1'b0;
		stall_cycles = 0;
		fail_count = 0;
		started = 0;
		tail_off = 0;
		brk_off = 0;
		base_reg = '0;
		limit_reg = ffha_pkg::HEAP_LIMIT_RST;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: size rounding, failure on growth, every free error and merging.
		push_req(ffha_pkg::OP_ALLOC, 17'd0, '0, a0);
		push_req(ffha_pkg::OP_ALLOC, 17'd1, '1, a1);
		push_req(ffha_pkg::OP_ALLOC, 17'd7, '0, a2);
		push_req(ffha_pkg::OP_ALLOC, 17'd100, '0, a3);
		push_req(ffha_pkg::OP_ALLOC, 17'd65536, '0, got);
		push_req(ffha_pkg::OP_FREE, 17'h1ffff, 32'd0, got);
		push_req(ffha_pkg::OP_FREE, '0, a0, got);
		push_req(ffha_pkg::OP_FREE, '0, a0, got);
		push_req(ffha_pkg::OP_FREE, '0, 32'd5, got);
		push_req(ffha_pkg::OP_FREE, '0, a1 + 8, got);
		push_req(ffha_pkg::OP_FREE, '0, 32'hffffffff, got);
		push_req(ffha_pkg::OP_ALLOC, 17'd8, '0, a0);
		push_req(ffha_pkg::OP_FREE, '0, a2, got);
		push_req(ffha_pkg::OP_FREE, '0, a1, got);
		push_req(ffha_pkg::OP_ALLOC, 17'd16, '0, got);
		push_req(ffha_pkg::OP_FREE, '0, a3, got);
		push_req(ffha_pkg::OP_ALLOC, 17'd2000, '0, a4);
		push_req(ffha_pkg::OP_ALLOC, 17'd64, '0, got);
		push_req(ffha_pkg::OP_FREE, '0, a4, got);
		push_req(ffha_pkg::OP_FREE, '0, a0, got);
		push_req(ffha_pkg::OP_ALLOC, 17'd300, '0, got);
		drain();

		random_phase(300);
		drain();
		write_reg(ffha_pkg::REG_HEAP_BASE, 32'h0000_1000);
		steady = 1'b1;
		random_phase(200);
		drain();
		steady = 1'b0;
		write_reg(ffha_pkg::REG_HEAP_BASE, 32'hffff_0000);
		write_reg(ffha_pkg::REG_HEAP_LIMIT, 32'd0);
		random_phase(250);
		drain();
		write_reg(ffha_pkg::REG_HEAP_BASE, $urandom() & 32'hffff_0000);
		write_reg(ffha_pkg::REG_HEAP_LIMIT, 32'd65536);
		random_phase(300);
		drain();
		write_reg(ffha_pkg::REG_HEAP_LIMIT, 32'($urandom_range(1000, 40000)));
		random_phase(300);
		drain();
		write_reg(ffha_pkg::REG_HEAP_BASE, 32'h5555_aaa8);
		write_reg(ffha_pkg::REG_HEAP_LIMIT, 32'd65535);
		random_phase(300);
		drain();
		write_reg(ffha_pkg::REG_HEAP_BASE, 32'd0);
		write_reg(ffha_pkg::REG_HEAP_LIMIT, 32'd65536);
		random_phase(280);
		drain();

		$display("covered %0d good allocations, %0d out-of-memory, %0d frees, %0d bad frees",
			n_alloc_ok, n_oom, n_free_ok, n_free_err);
		$display("across seven base and limit settings");
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> sim.f
hdl/ffha_pkg.sv
hdl/ffha_ram.sv
hdl/first_fit_heap_allocator.sv
bench/first_fit_heap_allocator_test.sv
